// File: src/fetiu_pkg.sv
// Shared types, codes and helpers of the escape-time iterate unit.
package fetiu_pkg;

    // Default geometry and number format
    localparam int DEF_IMAGE_WIDTH  = 1024;
    localparam int DEF_IMAGE_HEIGHT = 1024;
    localparam int DEF_FRAC_BITS    = 28;

    // Payload widths fixed by the item layout
    localparam int PIX_W  = 10;
    localparam int VAL_W  = 32;
    localparam int ITER_W = 16;

    // Wide working width for squares, sums and the mapped offset
    localparam int ACC_W = 68;

    // Shared multiplier operand width (33-bit window span fits)
    localparam int MUL_W = VAL_W + 1;

    // Mapping product span*pixel and its magnitude
    localparam int MAP_W = MUL_W + PIX_W + 1;

    typedef enum logic [2:0] {
        REG_VIEW_MIN_RE  = 3'd0,
        REG_VIEW_MAX_RE  = 3'd1,
        REG_VIEW_MIN_IM  = 3'd2,
        REG_VIEW_MAX_IM  = 3'd3,
        REG_JULIA_RE     = 3'd4,
        REG_JULIA_IM     = 3'd5,
        REG_MAX_ITER     = 3'd6,
        REG_FRACTAL_TYPE = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        FT_MANDELBROT = 2'd0,
        FT_JULIA      = 2'd1,
        FT_SHIP       = 2'd2,
        FT_RABBIT     = 2'd3
    } fractal_t;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(VAL_MAX);
        lo = ACC_W'(VAL_MIN);
        if (v > hi) begin
            return VAL_MAX;
        end else if (v < lo) begin
            return VAL_MIN;
        end else begin
            return v[VAL_W-1:0];
        end
    endfunction

    // |v| clamped; the most negative value maps to the most positive
    function automatic logic signed [VAL_W-1:0] abs32(input logic signed [VAL_W-1:0] v);
        if (v == VAL_MIN) begin
            return VAL_MAX;
        end else if (v < 0) begin
            return -v;
        end else begin
            return v;
        end
    endfunction

endpackage

// File: src/fetiu_mul.sv
// Shared signed multiplier with a registered product.
module fetiu_mul
    import fetiu_pkg::*;
#(
    parameter int OP_W = MUL_W
) (
    input  logic                       aclk,
    input  logic signed [OP_W-1:0]     op_a,
    input  logic signed [OP_W-1:0]     op_b,
    output logic signed [2*OP_W-1:0]   prod
);

    logic signed [2*OP_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// File: src/fetiu_div.sv
// Quotient fix-up for a reciprocal-multiply division by a constant.
module fetiu_div
    import fetiu_pkg::*;
#(
    parameter int NUM_W  = MUL_W,
    parameter int Q_W    = VAL_W,
    parameter int DSOR_W = 14
) (
    input  logic [NUM_W-1:0]  num,
    input  logic [NUM_W-1:0]  back,
    input  logic [DSOR_W-1:0] divisor,
    input  logic [Q_W-1:0]    q_est,
    output logic [Q_W-1:0]    quotient
);

    // Estimate is low by at most one, so num - q_est*divisor < 2*divisor
    logic [NUM_W-1:0] rem;

    always_comb begin
        rem      = num - back;
        quotient = q_est + Q_W'(rem >= NUM_W'(divisor));
    end

endmodule

// File: src/fractal_escape_time_iterate_unit.sv
// Top level: escape-time fractal iterator with window mapping and sequencer.
//
// Usage:
//   Input stream (s_*): one transaction per pixel, s_tdata = {pad, pixel_y, pixel_x}.
//   Output stream (m_*): one transaction per pixel, m_tdata = iter_count.
//   Config port: cfg_wr_en / cfg_addr / cfg_wdata, written only while idle.
//
// Sequence:
//   Each axis is mapped on the shared 33x33 multiplier: span/size
//   by reciprocal multiply, then pixel times quotient and remainder, with one
//   compare-and-add fix of the fractional quotient.
//   Each escape iteration then steps through zr*zr, zi*zi, zr*zi and update.
//   The iteration limit is checked at the zr*zr step and escape at the update
//   step; the count then goes to the output register and the sequencer goes
//   idle, so a new pixel is taken only once the previous count is registered.
//   The result sits in an output register, so a new pixel is accepted while
//   the previous count still waits for m_tready. If the receiver stalls and a
//   count is still held when the next one finishes, the sequencer waits.
//
// Reset (aresetn low, synchronous): registers return to the default window
//   (-2..1, -1.5..1.5), Mandelbrot, limit 64; any pixel in work is dropped.
module fractal_escape_time_iterate_unit
    import fetiu_pkg::*;
#(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,

    // Input transaction: [9:0] pixel_x, [19:10] pixel_y, [23:20] zero
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,

    // Output transaction: [15:0] iter_count
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,

    // Configuration writes
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_addr,
    input  logic [31:0]       cfg_wdata
);

    // Divisor width covers the larger image dimension
    localparam int DIM_MAX = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    localparam int DSOR_W  = $clog2(DIM_MAX + 1);
    localparam int REM_W   = DSOR_W + 1;
    localparam logic [DSOR_W-1:0] DIV_X = DSOR_W'(IMAGE_WIDTH);
    localparam logic [DSOR_W-1:0] DIV_Y = DSOR_W'(IMAGE_HEIGHT);

    // Reciprocals floor(2^32 / size); quotient estimate is low by at most one
    localparam int              RECIP_SHIFT = VAL_W;
    localparam longint unsigned RECIP_XV    = (64'd1 << RECIP_SHIFT) / IMAGE_WIDTH;
    localparam longint unsigned RECIP_YV    = (64'd1 << RECIP_SHIFT) / IMAGE_HEIGHT;
    localparam logic signed [MUL_W-1:0] RECIP_X = MUL_W'(RECIP_XV);
    localparam logic signed [MUL_W-1:0] RECIP_Y = MUL_W'(RECIP_YV);

    // Escape bound 4.0 at FRAC_BITS
    localparam logic signed [ACC_W-1:0] FOUR = ACC_W'(4) << FRAC_BITS;

    // Rabbit constant c = -0.125 + 0.745i, rounded to nearest
    localparam longint unsigned RABBIT_A  = 64'd1 << (FRAC_BITS - 3);
    localparam longint unsigned RABBIT_IM = (RABBIT_A / 25) * 149
                                          + ((RABBIT_A % 25) * 149 + 12) / 25;
    localparam logic signed [VAL_W-1:0] RABBIT_CI =
        (RABBIT_IM > 64'h7FFF_FFFF) ? VAL_MAX : VAL_W'(RABBIT_IM);
    localparam logic signed [VAL_W-1:0] RABBIT_CR =
        (FRAC_BITS - 3 >= 31) ? VAL_MIN : -(VAL_W'(RABBIT_A));

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP_REC,
        S_MAP_BACK,
        S_MAP_REM,
        S_MAP_FRAC,
        S_MAP_FREC,
        S_MAP_FBACK,
        S_MAP_FREM,
        S_MAP_SUM,
        S_MAP_SET,
        S_INIT,
        S_MRR,
        S_MII,
        S_MRI,
        S_UPD,
        S_OUT
    } state_t;

    // Configuration registers
    logic signed [VAL_W-1:0] view_min_re_reg;
    logic signed [VAL_W-1:0] view_max_re_reg;
    logic signed [VAL_W-1:0] view_min_im_reg;
    logic signed [VAL_W-1:0] view_max_im_reg;
    logic signed [VAL_W-1:0] julia_re_reg;
    logic signed [VAL_W-1:0] julia_im_reg;
    logic [ITER_W-1:0]       max_iter_reg;
    fractal_t                fractal_type_reg;

    // Sequencer and datapath state
    state_t                  state_reg;
    logic                    axis_reg;      // 0: real axis, 1: imaginary axis
    logic [PIX_W-1:0]        pix_x_reg;
    logic [PIX_W-1:0]        pix_y_reg;
    logic                    neg_reg;
    logic [VAL_W-1:0]        qa_reg;        // span/size estimate
    logic [REM_W-1:0]        rem_reg;       // span - qa*size, below 2*size
    logic [MAP_W-1:0]        hi_reg;        // qa*pixel
    logic [MUL_W-1:0]        t_reg;         // rem*pixel
    logic [VAL_W-1:0]        qb_reg;        // (rem*pixel)/size estimate
    logic [VAL_W-1:0]        q2_reg;        // (rem*pixel)/size, exact
    logic signed [MAP_W-1:0] off_reg;
    logic signed [VAL_W-1:0] px_reg;
    logic signed [VAL_W-1:0] py_reg;
    logic signed [VAL_W-1:0] zr_reg;
    logic signed [VAL_W-1:0] zi_reg;
    logic signed [VAL_W-1:0] cr_reg;
    logic signed [VAL_W-1:0] ci_reg;
    logic signed [ACC_W-1:0] sr_reg;
    logic signed [ACC_W-1:0] si_reg;
    logic [ITER_W-1:0]       n_reg;
    logic                    m_tvalid_reg;
    logic [ITER_W-1:0]       m_tdata_reg;

    // Shared multiplier
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] prod;

    // Quotient fix-up
    logic [DSOR_W-1:0] div_divisor;
    logic [VAL_W-1:0]  div_quotient;

    // Mapping and update terms
    logic signed [MUL_W-1:0] span;
    logic signed [MUL_W-1:0] span_mag;
    logic signed [VAL_W-1:0] view_min;
    logic [PIX_W-1:0]        pix_sel;
    logic signed [MUL_W-1:0] recip_sel;
    logic signed [MUL_W-1:0] div_const;
    logic [VAL_W-1:0]        prod_hi;
    logic [MUL_W-1:0]        rem_full;
    logic [MAP_W-1:0]        mag;
    logic signed [MAP_W-1:0] map_off;
    logic signed [VAL_W-1:0] map_val;
    logic signed [ACC_W-1:0] prod_wide;
    logic signed [ACC_W-1:0] sq_term;
    logic signed [ACC_W-1:0] cross_term;
    logic                    escaped;
    logic signed [VAL_W-1:0] nr;
    logic signed [VAL_W-1:0] ni;
    logic                    out_free;

    always_comb begin
        view_min  = axis_reg ? view_min_im_reg : view_min_re_reg;
        span      = axis_reg ? (MUL_W'(view_max_im_reg) - MUL_W'(view_min_im_reg))
                             : (MUL_W'(view_max_re_reg) - MUL_W'(view_min_re_reg));
        span_mag  = span[MUL_W-1] ? -span : span;
        pix_sel   = axis_reg ? pix_y_reg : pix_x_reg;
        recip_sel = axis_reg ? RECIP_Y : RECIP_X;
        div_const = axis_reg ? MUL_W'(DIV_Y) : MUL_W'(DIV_X);
    end

    // Operand select for the shared multiplier
    always_comb begin
        case (state_reg)
            S_MAP_REC: begin
                mul_a = span_mag;
                mul_b = recip_sel;
            end
            S_MAP_BACK, S_MAP_FBACK: begin
                mul_a = MUL_W'(prod_hi);
                mul_b = div_const;
            end
            S_MAP_REM: begin
                mul_a = MUL_W'(qa_reg);
                mul_b = MUL_W'({1'b0, pix_sel});
            end
            S_MAP_FRAC: begin
                mul_a = MUL_W'(rem_reg);
                mul_b = MUL_W'({1'b0, pix_sel});
            end
            S_MAP_FREC: begin
                mul_a = prod[MUL_W-1:0];
                mul_b = recip_sel;
            end
            S_MRR: begin
                mul_a = MUL_W'(zr_reg);
                mul_b = MUL_W'(zr_reg);
            end
            S_MII: begin
                mul_a = MUL_W'(zi_reg);
                mul_b = MUL_W'(zi_reg);
            end
            default: begin
                mul_a = MUL_W'(zr_reg);
                mul_b = MUL_W'(zi_reg);
            end
        endcase
    end

    fetiu_mul #(
        .OP_W (MUL_W)
    ) u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Mapping: |span|*pixel/size as qa*pixel + (rem*pixel)/size, sign restored
    always_comb begin
        prod_hi     = prod[RECIP_SHIFT +: VAL_W];
        rem_full    = span_mag - prod[MUL_W-1:0];
        div_divisor = axis_reg ? DIV_Y : DIV_X;
        mag         = hi_reg + MAP_W'(q2_reg);
        map_off     = neg_reg ? -$signed(mag) : $signed(mag);
        map_val     = sat32(ACC_W'(view_min) + ACC_W'(off_reg));
    end

    fetiu_div #(
        .NUM_W  (MUL_W),
        .Q_W    (VAL_W),
        .DSOR_W (DSOR_W)
    ) u_div (
        .num      (t_reg),
        .back     (prod[MUL_W-1:0]),
        .divisor  (div_divisor),
        .q_est    (qb_reg),
        .quotient (div_quotient)
    );

    // Iteration terms; product register holds zr*zi in S_UPD
    always_comb begin
        prod_wide  = ACC_W'(prod);
        sq_term    = prod_wide >>> FRAC_BITS;
        cross_term = prod_wide >>> (FRAC_BITS - 1);
        escaped    = (sr_reg + si_reg) >= FOUR;
        nr         = sat32(sr_reg - si_reg + ACC_W'(cr_reg));
        ni         = sat32(cross_term + ACC_W'(ci_reg));
        if (fractal_type_reg == FT_SHIP) begin
            nr = abs32(nr);
            ni = abs32(ni);
        end
        out_free   = !m_tvalid_reg || m_tready;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_min_re_reg  <= -32'sd536870912;
            view_max_re_reg  <= 32'sd268435456;
            view_min_im_reg  <= -32'sd402653184;
            view_max_im_reg  <= 32'sd402653184;
            julia_re_reg     <= '0;
            julia_im_reg     <= '0;
            max_iter_reg     <= ITER_W'(64);
            fractal_type_reg <= FT_MANDELBROT;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_addr))
                REG_VIEW_MIN_RE:  view_min_re_reg  <= cfg_wdata;
                REG_VIEW_MAX_RE:  view_max_re_reg  <= cfg_wdata;
                REG_VIEW_MIN_IM:  view_min_im_reg  <= cfg_wdata;
                REG_VIEW_MAX_IM:  view_max_im_reg  <= cfg_wdata;
                REG_JULIA_RE:     julia_re_reg     <= cfg_wdata;
                REG_JULIA_IM:     julia_im_reg     <= cfg_wdata;
                REG_MAX_ITER:     max_iter_reg     <= cfg_wdata[ITER_W-1:0];
                REG_FRACTAL_TYPE: fractal_type_reg <= fractal_t'(cfg_wdata[1:0]);
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            axis_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Load a new count, or drop the held one once taken
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        pix_x_reg <= s_tdata[PIX_W-1:0];
                        pix_y_reg <= s_tdata[2*PIX_W-1:PIX_W];
                        axis_reg  <= 1'b0;
                        state_reg <= S_MAP_REC;
                    end
                end
                S_MAP_REC: begin
                    neg_reg   <= span[MUL_W-1];
                    state_reg <= S_MAP_BACK;
                end
                S_MAP_BACK: begin
                    qa_reg    <= prod_hi;
                    state_reg <= S_MAP_REM;
                end
                S_MAP_REM: begin
                    rem_reg   <= REM_W'(rem_full);
                    state_reg <= S_MAP_FRAC;
                end
                S_MAP_FRAC: begin
                    hi_reg    <= prod[MAP_W-1:0];
                    state_reg <= S_MAP_FREC;
                end
                S_MAP_FREC: begin
                    t_reg     <= prod[MUL_W-1:0];
                    state_reg <= S_MAP_FBACK;
                end
                S_MAP_FBACK: begin
                    qb_reg    <= prod_hi;
                    state_reg <= S_MAP_FREM;
                end
                S_MAP_FREM: begin
                    q2_reg    <= div_quotient;
                    state_reg <= S_MAP_SUM;
                end
                S_MAP_SUM: begin
                    off_reg   <= map_off;
                    state_reg <= S_MAP_SET;
                end
                S_MAP_SET: begin
                    if (axis_reg) begin
                        py_reg    <= map_val;
                        state_reg <= S_INIT;
                    end else begin
                        px_reg    <= map_val;
                        axis_reg  <= 1'b1;
                        state_reg <= S_MAP_REC;
                    end
                end
                S_INIT: begin
                    n_reg <= '0;
                    case (fractal_type_reg)
                        FT_JULIA: begin
                            zr_reg <= px_reg;
                            zi_reg <= py_reg;
                            cr_reg <= julia_re_reg;
                            ci_reg <= julia_im_reg;
                        end
                        FT_RABBIT: begin
                            zr_reg <= px_reg;
                            zi_reg <= py_reg;
                            cr_reg <= RABBIT_CR;
                            ci_reg <= RABBIT_CI;
                        end
                        default: begin
                            zr_reg <= '0;
                            zi_reg <= '0;
                            cr_reg <= px_reg;
                            ci_reg <= py_reg;
                        end
                    endcase
                    state_reg <= S_MRR;
                end
                S_MRR: begin
                    state_reg <= (n_reg == max_iter_reg) ? S_OUT : S_MII;
                end
                S_MII: begin
                    sr_reg    <= sq_term;
                    state_reg <= S_MRI;
                end
                S_MRI: begin
                    si_reg    <= sq_term;
                    state_reg <= S_UPD;
                end
                S_UPD: begin
                    if (escaped) begin
                        state_reg <= S_OUT;
                    end else begin
                        zr_reg    <= nr;
                        zi_reg    <= ni;
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= S_MRR;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tdata_reg <= n_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: bench/tb.sv
// Self-checking bench for the escape-time iterate unit: directed and random pixel streams.
module tb;
    import fetiu_pkg::*;

    localparam int IMG_W         = DEF_IMAGE_WIDTH;
    localparam int IMG_H         = DEF_IMAGE_HEIGHT;
    localparam int FB            = DEF_FRAC_BITS;
    localparam int RANDOM_PIXELS = 1450;

    // Expected iteration counts, predicted from a private copy of the registers.
    class escape_ledger;
        logic signed [VAL_W-1:0] re_lo, re_hi, im_lo, im_hi, jc_re, jc_im;
        logic [ITER_W-1:0]       limit;
        fractal_t                kind;
        logic [ITER_W-1:0]       want_counts[$];
        int                      mismatches;

        function new();
            re_lo      = 32'hE000_0000;
            re_hi      = 32'h1000_0000;
            im_lo      = 32'hE800_0000;
            im_hi      = 32'h1800_0000;
            jc_re      = '0;
            jc_im      = '0;
            limit      = 16'd64;
            kind       = FT_MANDELBROT;
            mismatches = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [31:0] d);
            case (idx)
                REG_VIEW_MIN_RE:  re_lo = d;
                REG_VIEW_MAX_RE:  re_hi = d;
                REG_VIEW_MIN_IM:  im_lo = d;
                REG_VIEW_MAX_IM:  im_hi = d;
                REG_JULIA_RE:     jc_re = d;
                REG_JULIA_IM:     jc_im = d;
                REG_MAX_ITER:     limit = d[ITER_W-1:0];
                REG_FRACTAL_TYPE: kind  = fractal_t'(d[1:0]);
                default: ;
            endcase
        endfunction

        static function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // min + pix*(max-min)/extent, quotient truncated toward zero
        static function longint map_pixel(logic [PIX_W-1:0] pix, logic signed [31:0] lo,
                                          logic signed [31:0] hi, int extent);
            longint span;
            longint off;
            span = longint'(hi) - longint'(lo);
            off  = (span * longint'(pix)) / extent;
            return clamp32(longint'(lo) + off);
        endfunction

        function logic [ITER_W-1:0] predict_escape_count(logic [PIX_W-1:0] x,
                                                         logic [PIX_W-1:0] y);
            longint px, py, zr, zi, cr, ci, sr, si, nr, ni, quot, rem;
            int     n;
            bit     escaped;
            px = map_pixel(x, re_lo, re_hi, IMG_W);
            py = map_pixel(y, im_lo, im_hi, IMG_H);
            case (kind)
                FT_JULIA: begin
                    zr = px; zi = py; cr = jc_re; ci = jc_im;
                end
                FT_RABBIT: begin
                    // c = -0.125 + 0.745i, imaginary part rounded to nearest
                    zr   = px; zi = py;
                    cr   = -(64'sd1 <<< (FB - 3));
                    quot = (64'sd1 <<< (FB - 3)) / 25;
                    rem  = (64'sd1 <<< (FB - 3)) % 25;
                    ci   = clamp32(quot * 149 + (rem * 149 + 12) / 25);
                end
                default: begin
                    zr = 0; zi = 0; cr = px; ci = py;
                end
            endcase
            n       = 0;
            escaped = 1'b0;
            while (n < int'(limit) && !escaped) begin
                sr = (zr * zr) >>> FB;
                si = (zi * zi) >>> FB;
                if (sr + si >= (64'sd4 <<< FB)) begin
                    escaped = 1'b1;
                end else begin
                    nr = clamp32(sr - si + cr);
                    ni = clamp32(((zr * zi) >>> (FB - 1)) + ci);
                    if (kind == FT_SHIP) begin
                        nr = clamp32(nr < 0 ? -nr : nr);
                        ni = clamp32(ni < 0 ? -ni : ni);
                    end
                    zr = nr;
                    zi = ni;
                    n++;
                end
            end
            return n[ITER_W-1:0];
        endfunction

        function void note_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
            want_counts.push_back(predict_escape_count(x, y));
        endfunction

        function void check_count(logic [ITER_W-1:0] got);
            logic [ITER_W-1:0] want;
            if (want_counts.size() == 0) begin
                $error("iter_count: expected none, got %0d", got);
                mismatches++;
                return;
            end
            want = want_counts.pop_front();
            if (got !== want) begin
                $error("iter_count: expected %0d, got %0d", want, got);
                mismatches++;
            end
        endfunction

        function int pending();
            return want_counts.size();
        endfunction
    endclass

    // DUT stimulus, all known from time zero
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;    // [9:0] pixel_x, [19:10] pixel_y, [23:20] zero
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;           // [15:0] iter_count
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [31:0] cfg_wdata = '0;

    // steady: no idling on either side while set
    bit           steady = 1'b0;
    escape_ledger ledger;

    // Register values queued for the next idle window, with a select mask
    logic [31:0] next_regs [8];
    logic [7:0]  next_sel;

    fractal_escape_time_iterate_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run (one 65535-iteration pixel included)
    initial begin
        #50_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // Result side: back-pressure roughly 8% of cycles outside the steady stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(0, 99) >= 8);
        end
    end

    // Result monitor; values read here are the ones present at the edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            ledger.check_count(m_tdata);
        end
    end

    // One pixel transaction. valid stays high into the next call unless a gap is drawn,
    // so it is never lowered and raised in the same step.
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 8) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, py, px};
        do @(posedge aclk); while (!s_tready);
        ledger.note_pixel(px, py);
    endtask

    // Stop sending and hold off until every outstanding count has come back
    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge aclk);
    endtask

    task automatic stage(input reg_idx_t idx, input logic [31:0] v);
        next_regs[idx] = v;
        next_sel[idx]  = 1'b1;
    endtask

    // Write the staged registers, one per cycle; block must be idle here
    task automatic reconfigure();
        for (int i = 0; i < 8; i++) begin
            if (next_sel[i]) begin
                cfg_wr_en <= 1'b1;
                cfg_addr  <= 3'(i);
                cfg_wdata <= next_regs[i];
                @(posedge aclk);
                ledger.write_reg(reg_idx_t'(i), next_regs[i]);
            end
        end
        cfg_wr_en <= 1'b0;
        next_sel = '0;
    endtask

    // Window edges: mostly a zoom around an interesting center, sometimes
    // arbitrary or full-range, and now and then reversed.
    task automatic pick_window(input int center, output logic [31:0] lo,
                               output logic [31:0] hi);
        int          mid;
        int          half;
        logic [31:0] t;
        case ($urandom_range(0, 9))
            0: begin
                lo = $urandom;
                hi = $urandom;
            end
            1: begin
                lo = 32'h8000_0000;
                hi = 32'h7FFF_FFFF;
            end
            default: begin
                mid  = center + int'($urandom_range(0, 32'h3000_0000)) - 32'sh1800_0000;
                half = 1 << $urandom_range(16, 29);
                lo   = mid - half;
                hi   = mid + half;
            end
        endcase
        if ($urandom_range(0, 4) == 0) begin
            t  = lo;
            lo = hi;
            hi = t;
        end
    endtask

    function automatic logic [31:0] pick_julia_part();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
    endfunction

    task automatic stage_random_setup();
        logic [31:0] lo, hi;
        logic [15:0] lim;
        pick_window(-32'sh0800_0000, lo, hi);
        stage(REG_VIEW_MIN_RE, lo);
        stage(REG_VIEW_MAX_RE, hi);
        pick_window(0, lo, hi);
        stage(REG_VIEW_MIN_IM, lo);
        stage(REG_VIEW_MAX_IM, hi);
        stage(REG_JULIA_RE, pick_julia_part());
        stage(REG_JULIA_IM, pick_julia_part());
        // Limits kept small so the run stays short; zero shows up now and then
        case ($urandom_range(0, 19))
            0:             lim = '0;
            1, 2, 3, 4, 5: lim = 16'($urandom_range(65, 160));
            default:       lim = 16'($urandom_range(1, 64));
        endcase
        // Junk in the upper bits must be dropped by the narrow registers
        stage(REG_MAX_ITER, {16'($urandom), lim});
        stage(REG_FRACTAL_TYPE, {30'($urandom), 2'($urandom_range(0, 3))});
        // Sometimes keep part of the previous setting
        if ($urandom_range(0, 3) == 0) next_sel = next_sel & 8'($urandom);
    endtask

    initial begin
        int sent;
        int phase_len;
        ledger   = new();
        next_sel = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: Mandelbrot over -2..1 x -1.5..1.5, limit 64.
        // Corners escape at once, the near-origin and -0.5 pixels run to the limit.
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd682, 10'd512);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
        wait_results();

        // Zero limit, written with junk above the 16-bit field
        stage(REG_MAX_ITER, 32'hFFFF_0000);
        reconfigure();
        send_pixel(10'd682, 10'd512);
        send_pixel(10'd1023, 10'd1023);
        wait_results();

        // Julia, c = -0.8 + 0.156i; type code carried in the low two bits only
        stage(REG_JULIA_RE, -32'sd214748365);
        stage(REG_JULIA_IM, 32'sd41875931);
        stage(REG_MAX_ITER, 32'd100);
        stage(REG_FRACTAL_TYPE, {30'h3FFF_FFFF, FT_JULIA});
        reconfigure();
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd300, 10'd700);
        send_pixel(10'd0, 10'd0);
        wait_results();

        // Burning Ship over -2.5..1.5 x -2..1
        stage(REG_VIEW_MIN_RE, 32'hD800_0000);
        stage(REG_VIEW_MAX_RE, 32'h1800_0000);
        stage(REG_VIEW_MIN_IM, 32'hE000_0000);
        stage(REG_VIEW_MAX_IM, 32'h1000_0000);
        stage(REG_FRACTAL_TYPE, {30'b0, FT_SHIP});
        reconfigure();
        send_pixel(10'd700, 10'd300);
        send_pixel(10'd512, 10'd900);
        send_pixel(10'd100, 10'd100);
        wait_results();

        // Rabbit: the Julia constant registers hold extremes and must not matter
        stage(REG_VIEW_MIN_RE, 32'hE800_0000);
        stage(REG_VIEW_MAX_RE, 32'h1800_0000);
        stage(REG_VIEW_MIN_IM, 32'hE800_0000);
        stage(REG_VIEW_MAX_IM, 32'h1800_0000);
        stage(REG_JULIA_RE, 32'h7FFF_FFFF);
        stage(REG_JULIA_IM, 32'h8000_0000);
        stage(REG_FRACTAL_TYPE, {30'b0, FT_RABBIT});
        reconfigure();
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd400, 10'd600);
        send_pixel(10'd1023, 10'd512);
        wait_results();

        // Full-range window, imaginary axis reversed; large c drives saturation
        stage(REG_VIEW_MIN_RE, 32'h8000_0000);
        stage(REG_VIEW_MAX_RE, 32'h7FFF_FFFF);
        stage(REG_VIEW_MIN_IM, 32'h7FFF_FFFF);
        stage(REG_VIEW_MAX_IM, 32'h8000_0000);
        stage(REG_MAX_ITER, 32'h1234_0014);
        stage(REG_FRACTAL_TYPE, {30'h3FFF_FFFF, FT_MANDELBROT});
        reconfigure();
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd600, 10'd400);
        wait_results();

        // Largest limit: pixel (0,0) maps to c = 0 and runs all 65535 iterations
        stage(REG_VIEW_MIN_RE, 32'h0000_0000);
        stage(REG_VIEW_MAX_RE, 32'h7FFF_FFFF);
        stage(REG_VIEW_MIN_IM, 32'h0000_0000);
        stage(REG_VIEW_MAX_IM, 32'h7FFF_FFFF);
        stage(REG_MAX_ITER, 32'h0000_FFFF);
        reconfigure();
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd200, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        wait_results();

        // Random phases: fresh registers, a burst of pixels, then a full drain.
        // Pixels 400..699 run with no idling on either side.
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            stage_random_setup();
            reconfigure();
            phase_len = $urandom_range(15, 60);
            for (int k = 0; k < phase_len && sent < RANDOM_PIXELS; k++) begin
                steady = (sent >= 400 && sent < 700);
                send_pixel(10'($urandom), 10'($urandom));
                sent++;
            end
            wait_results();
        end
        steady = 1'b0;

        // Room for a stray extra transaction to show up
        repeat (40) @(posedge aclk);
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
